// ===== design/tbrs_pkg.sv =====
// Shared types, widths and constants of the token bucket rate shaper.
package tbrs_pkg;

   localparam int NUM_BUCKETS = 256;
   localparam int IDX_W       = $clog2(NUM_BUCKETS);

   localparam int OP_W     = 2;
   localparam int BKT_W    = 8;
   localparam int TIME_W   = 64;
   localparam int LEN_W    = 16;
   localparam int RATE_W   = 40;
   localparam int TOK_W    = 44;
   localparam int HZ_W     = 33;
   localparam int BRATE_W  = 47;
   localparam int PROD_W   = 128;
   localparam int QUO_W    = 64;
   localparam int CNT_W    = 7;
   localparam int PADDR_W  = 4;
   localparam int PDATA_W  = 64;

   localparam logic [HZ_W-1:0]  HZ_RESET  = 33'd1000000000;
   localparam logic [TOK_W-1:0] MIN_DEPTH = 44'd2048;

   localparam logic [CNT_W-1:0] MUL1_BITS = CNT_W'(BRATE_W);
   localparam logic [CNT_W-1:0] DIV1_BITS = CNT_W'(TIME_W + BRATE_W);
   localparam logic [CNT_W-1:0] MUL2_BITS = CNT_W'(HZ_W);
   localparam logic [CNT_W-1:0] DIV2_BITS = CNT_W'(TOK_W + HZ_W);

   typedef enum logic [OP_W-1:0] {
      OP_INIT    = 2'd0,
      OP_CHECK   = 2'd1,
      OP_CONSUME = 2'd2,
      OP_PAIR    = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [RATE_W-1:0] rate;
      logic [TOK_W-1:0]  depth;
      logic [TOK_W-1:0]  tokens;
      logic [TIME_W-1:0] last;
   } bucket_type;

   localparam int ENTRY_W = $bits(bucket_type);

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LATCH,
      CMD_WR_INIT,
      CMD_RESP_NONE,
      CMD_RD_A,
      CMD_RD_B,
      CMD_LOAD_W,
      CMD_RESP_CHECK,
      CMD_RESP_TOK,
      CMD_REF_START,
      CMD_DIV1_START,
      CMD_DIV1_END,
      CMD_DIV2_START,
      CMD_DIV2_END,
      CMD_SAVE_A,
      CMD_DECIDE,
      CMD_WR_A,
      CMD_WR_A_RESP,
      CMD_WR_B_RESP
   } cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       a_ok;
      logic       b_ok;
      logic       pair;
      logic       ref_trivial;
      logic       arith_done;
      logic       q_partial;
   } status_type;

endpackage

// ===== design/tbrs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tbrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== design/tbrs_arith.sv =====
// Bit-serial shift-add multiplier and restoring divider sharing the operand registers.
module tbrs_arith (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          is_div,
   input  logic [tbrs_pkg::CNT_W-1:0]    count,
   input  logic [tbrs_pkg::PROD_W-1:0]   op_a,
   input  logic [tbrs_pkg::BRATE_W-1:0]  op_b,
   output logic                          done,
   output logic [tbrs_pkg::PROD_W-1:0]   product,
   output logic [tbrs_pkg::QUO_W-1:0]    quotient,
   output logic                          quo_big
);
   import tbrs_pkg::*;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic                 div_ff, div_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [PROD_W-1:0]    mc_ff, mc_in;
   logic [BRATE_W-1:0]   mp_ff, mp_in;
   logic [PROD_W-1:0]    acc_ff, acc_in;
   logic [BRATE_W-1:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]     q_ff, q_in;
   logic                 big_ff, big_in;
   logic [CNT_W-1:0]     bit_idx;
   logic [BRATE_W:0]     r2;
   logic                 ge;

   always_comb begin
      bit_idx = cnt_ff - CNT_W'(1);
      r2      = {rem_ff, mc_ff[bit_idx]};
      ge      = (r2 >= {1'b0, mp_ff});
      run_in  = run_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      big_in  = big_ff;
      if (start) begin
         run_in = 1'b1;
         div_in = is_div;
         cnt_in = count;
         mc_in  = op_a;
         mp_in  = op_b;
         acc_in = '0;
         rem_in = '0;
         q_in   = '0;
         big_in = 1'b0;
      end else if (run_ff) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
         if (div_ff) begin
            rem_in = ge ? BRATE_W'(r2 - {1'b0, mp_ff}) : BRATE_W'(r2);
            q_in   = {q_ff[QUO_W-2:0], ge};
            big_in = big_ff | q_ff[QUO_W-1];
         end else begin
            acc_in = mp_ff[0] ? (acc_ff + mc_ff) : acc_ff;
            mc_in  = {mc_ff[PROD_W-2:0], 1'b0};
            mp_in  = {1'b0, mp_ff[BRATE_W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      big_ff <= big_in;
   end

   assign done     = done_ff;
   assign product  = acc_ff;
   assign quotient = q_ff;
   assign quo_big  = big_ff;
endmodule

// ===== design/tbrs_datapath.sv =====
// Datapath: request registers, bucket memory, refill arithmetic and result registers.
module tbrs_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  tbrs_pkg::cmd_type              cmd,
   output tbrs_pkg::status_type           status,
   input  logic [tbrs_pkg::OP_W-1:0]      req_opcode,
   input  logic [tbrs_pkg::BKT_W-1:0]     req_first_bucket,
   input  logic [tbrs_pkg::BKT_W-1:0]     req_second_bucket,
   input  logic [tbrs_pkg::TIME_W-1:0]    req_timestamp,
   input  logic [tbrs_pkg::LEN_W-1:0]     req_packet_length,
   input  logic [tbrs_pkg::RATE_W-1:0]    req_rate_kbps,
   output logic                           rsp_strobe,
   output logic                           rsp_granted,
   output logic [tbrs_pkg::TOK_W-1:0]     rsp_tokens_left,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tbrs_pkg::PADDR_W-1:0]   paddr,
   input  logic [tbrs_pkg::PDATA_W-1:0]   pwdata,
   output logic [tbrs_pkg::PDATA_W-1:0]   prdata,
   output logic                           pready
);
   import tbrs_pkg::*;

   logic [HZ_W-1:0]     hz_ff;
   logic [HZ_W-1:0]     hz_eff;
   opcode_type          op_ff;
   logic [BKT_W-1:0]    a_ff, b_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [LEN_W-1:0]    len_ff;
   logic [RATE_W-1:0]   rate_ff;
   logic [NUM_BUCKETS-1:0] vld_ff;
   logic                rd_vld_ff;
   bucket_type          w_ff, a_ent_ff;
   logic [BRATE_W-1:0]  brate_ff;
   logic                grant_ff;
   logic                strobe_ff;
   logic                granted_ff;
   logic [TOK_W-1:0]    tokens_ff;

   logic [IDX_W-1:0]    a_idx, b_idx, raddr, waddr;
   logic                we;
   bucket_type          wdata, rdata, rd_ent;
   logic [BRATE_W+1:0]  rate_x100;
   logic [TOK_W-1:0]    depth_calc, depth_init;
   logic [BRATE_W-1:0]  brate;
   logic [TIME_W-1:0]   elapsed;
   logic [TOK_W-1:0]    need;
   logic                q_zero, q_full;
   logic [TIME_W-1:0]   used;
   logic [TOK_W-1:0]    take;
   logic                ar_start, ar_div;
   logic [CNT_W-1:0]    ar_count;
   logic [PROD_W-1:0]   ar_a;
   logic [BRATE_W-1:0]  ar_b;
   logic                ar_done, ar_big;
   logic [PROD_W-1:0]   ar_prod;
   logic [QUO_W-1:0]    ar_quo;
   logic                csr_wr;

   assign hz_eff = (hz_ff == '0) ? HZ_W'(1) : hz_ff;
   assign a_idx  = IDX_W'(a_ff);
   assign b_idx  = IDX_W'(b_ff);
   assign raddr  = (cmd == CMD_RD_B) ? b_idx : a_idx;
   assign rd_ent = rd_vld_ff ? rdata : '0;

   assign rate_x100  = ({rate_ff, 6'b0} + {1'b0, rate_ff, 5'b0}) + (BRATE_W+2)'({rate_ff, 2'b0});
   assign depth_calc = TOK_W'((rate_x100 + (BRATE_W+2)'(7)) >> 3);
   assign depth_init = (rate_ff == '0) ? '0 :
                       ((depth_calc < MIN_DEPTH) ? MIN_DEPTH : depth_calc);

   assign brate   = ({w_ff.rate, 7'b0} - BRATE_W'({w_ff.rate, 1'b0})) - BRATE_W'(w_ff.rate);
   assign elapsed = now_ff - w_ff.last;
   assign need    = w_ff.depth - w_ff.tokens;
   assign q_zero  = !ar_big && (ar_quo == '0);
   assign q_full  = ar_big || (ar_quo[QUO_W-1:TOK_W] != '0) || (ar_quo[TOK_W-1:0] >= need);
   assign used    = (ar_quo == '0) ? TIME_W'(1) : ar_quo;
   assign take    = grant_ff ? TOK_W'(len_ff) : '0;

   always_comb begin
      ar_start = 1'b0;
      ar_div   = 1'b0;
      ar_count = MUL1_BITS;
      ar_a     = PROD_W'(elapsed);
      ar_b     = brate;
      case (cmd)
         CMD_REF_START: begin
            ar_start = !status.ref_trivial;
         end
         CMD_DIV1_START: begin
            ar_start = 1'b1;
            ar_div   = 1'b1;
            ar_count = DIV1_BITS;
            ar_a     = ar_prod;
            ar_b     = BRATE_W'(hz_eff);
         end
         CMD_DIV1_END: begin
            ar_start = status.q_partial;
            ar_count = MUL2_BITS;
            ar_a     = PROD_W'(ar_quo[TOK_W-1:0]);
            ar_b     = BRATE_W'(hz_eff);
         end
         CMD_DIV2_START: begin
            ar_start = 1'b1;
            ar_div   = 1'b1;
            ar_count = DIV2_BITS;
            ar_a     = ar_prod;
            ar_b     = brate_ff;
         end
         default: begin
            ar_start = 1'b0;
         end
      endcase
   end

   always_comb begin
      we    = 1'b0;
      waddr = a_idx;
      wdata = a_ent_ff;
      case (cmd)
         CMD_WR_INIT: begin
            we    = 1'b1;
            wdata = '{rate: rate_ff, depth: depth_init, tokens: depth_init, last: now_ff};
         end
         CMD_WR_A, CMD_WR_A_RESP: begin
            we           = 1'b1;
            wdata.tokens = a_ent_ff.tokens - take;
         end
         CMD_WR_B_RESP: begin
            we           = 1'b1;
            waddr        = b_idx;
            wdata        = w_ff;
            wdata.tokens = w_ff.tokens - take;
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   tbrs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_BUCKETS)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   tbrs_arith u_arith (
      .clock    (clock),
      .reset    (reset),
      .start    (ar_start),
      .is_div   (ar_div),
      .count    (ar_count),
      .op_a     (ar_a),
      .op_b     (ar_b),
      .done     (ar_done),
      .product  (ar_prod),
      .quotient (ar_quo),
      .quo_big  (ar_big)
   );

   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hz_ff     <= HZ_RESET;
         vld_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         if (csr_wr && !paddr[3]) begin
            hz_ff <= pwdata[HZ_W-1:0];
         end
         if (we) begin
            vld_ff[waddr] <= 1'b1;
         end
         strobe_ff <= (cmd == CMD_WR_INIT) || (cmd == CMD_RESP_NONE) ||
                      (cmd == CMD_RESP_CHECK) || (cmd == CMD_RESP_TOK) ||
                      (cmd == CMD_WR_A_RESP) || (cmd == CMD_WR_B_RESP);
      end
      rd_vld_ff <= vld_ff[raddr];
      case (cmd)
         CMD_LATCH: begin
            op_ff   <= opcode_type'(req_opcode);
            a_ff    <= req_first_bucket;
            b_ff    <= req_second_bucket;
            now_ff  <= req_timestamp;
            len_ff  <= req_packet_length;
            rate_ff <= req_rate_kbps;
         end
         CMD_WR_INIT: begin
            granted_ff <= 1'b1;
            tokens_ff  <= depth_init;
         end
         CMD_RESP_NONE: begin
            granted_ff <= 1'b0;
            tokens_ff  <= '0;
         end
         CMD_LOAD_W: begin
            w_ff <= rd_ent;
         end
         CMD_RESP_CHECK: begin
            granted_ff <= (w_ff.depth != '0) && (TOK_W'(len_ff) <= w_ff.depth);
            tokens_ff  <= w_ff.tokens;
         end
         CMD_RESP_TOK: begin
            granted_ff <= 1'b0;
            tokens_ff  <= w_ff.tokens;
         end
         CMD_REF_START: begin
            brate_ff <= brate;
            if (w_ff.rate == '0 || w_ff.depth == '0) begin
               w_ff.tokens <= '0;
               w_ff.last   <= now_ff;
            end else if (w_ff.tokens >= w_ff.depth) begin
               w_ff.tokens <= w_ff.depth;
               w_ff.last   <= now_ff;
            end
         end
         CMD_DIV1_END: begin
            if (!q_zero) begin
               if (q_full) begin
                  w_ff.tokens <= w_ff.depth;
                  w_ff.last   <= now_ff;
               end else begin
                  w_ff.tokens <= w_ff.tokens + ar_quo[TOK_W-1:0];
               end
            end
         end
         CMD_DIV2_END: begin
            w_ff.last <= w_ff.last + used;
         end
         CMD_SAVE_A: begin
            a_ent_ff <= w_ff;
         end
         CMD_DECIDE: begin
            grant_ff <= (a_ent_ff.tokens >= TOK_W'(len_ff)) &&
                        (!status.pair || (w_ff.tokens >= TOK_W'(len_ff)));
         end
         CMD_WR_A, CMD_WR_A_RESP: begin
            granted_ff <= grant_ff;
            tokens_ff  <= a_ent_ff.tokens - take;
         end
         default: begin
            granted_ff <= granted_ff;
         end
      endcase
   end

   always_comb begin
      status.op          = op_ff;
      status.a_ok        = (32'(a_ff) < NUM_BUCKETS);
      status.b_ok        = (32'(b_ff) < NUM_BUCKETS);
      status.pair        = (op_ff == OP_PAIR) && (a_ff != b_ff);
      status.ref_trivial = (w_ff.rate == '0) || (w_ff.depth == '0) ||
                           (w_ff.tokens >= w_ff.depth);
      status.arith_done  = ar_done;
      status.q_partial   = !q_zero && !q_full;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_granted     = granted_ff;
   assign rsp_tokens_left = tokens_ff;
   assign pready          = 1'b1;
   assign prdata          = paddr[3] ? '0 : PDATA_W'(hz_ff);
endmodule

// ===== design/tbrs_ctrl.sv =====
// Controller state machine that sequences each transaction through the datapath.
module tbrs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tbrs_pkg::status_type  status,
   output tbrs_pkg::cmd_type     cmd
);
   import tbrs_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_LOAD_A,
      ST_SHORT,
      ST_REF0,
      ST_MUL1,
      ST_DIV1,
      ST_MUL2,
      ST_DIV2,
      ST_REF_END,
      ST_RD_B,
      ST_LOAD_B,
      ST_DECIDE,
      ST_WR_A,
      ST_WR_B
   } state_type;

   state_type state_ff, state_in;
   logic      phase_ff, phase_in;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd      = CMD_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd      = CMD_LATCH;
               phase_in = 1'b0;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (!status.a_ok) begin
               cmd      = CMD_RESP_NONE;
               state_in = ST_IDLE;
            end else if (status.op == OP_INIT) begin
               cmd      = CMD_WR_INIT;
               state_in = ST_IDLE;
            end else begin
               cmd      = CMD_RD_A;
               state_in = ST_LOAD_A;
            end
         end
         ST_LOAD_A: begin
            cmd = CMD_LOAD_W;
            if (status.op == OP_CHECK || (status.pair && !status.b_ok)) begin
               state_in = ST_SHORT;
            end else begin
               state_in = ST_REF0;
            end
         end
         ST_SHORT: begin
            cmd      = (status.op == OP_CHECK) ? CMD_RESP_CHECK : CMD_RESP_TOK;
            state_in = ST_IDLE;
         end
         ST_REF0: begin
            cmd      = CMD_REF_START;
            state_in = status.ref_trivial ? ST_REF_END : ST_MUL1;
         end
         ST_MUL1: begin
            if (status.arith_done) begin
               cmd      = CMD_DIV1_START;
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (status.arith_done) begin
               cmd      = CMD_DIV1_END;
               state_in = status.q_partial ? ST_MUL2 : ST_REF_END;
            end
         end
         ST_MUL2: begin
            if (status.arith_done) begin
               cmd      = CMD_DIV2_START;
               state_in = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (status.arith_done) begin
               cmd      = CMD_DIV2_END;
               state_in = ST_REF_END;
            end
         end
         ST_REF_END: begin
            if (!phase_ff) begin
               cmd      = CMD_SAVE_A;
               state_in = status.pair ? ST_RD_B : ST_DECIDE;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_RD_B: begin
            cmd      = CMD_RD_B;
            phase_in = 1'b1;
            state_in = ST_LOAD_B;
         end
         ST_LOAD_B: begin
            cmd      = CMD_LOAD_W;
            state_in = ST_REF0;
         end
         ST_DECIDE: begin
            cmd      = CMD_DECIDE;
            state_in = ST_WR_A;
         end
         ST_WR_A: begin
            if (status.pair) begin
               cmd      = CMD_WR_A;
               state_in = ST_WR_B;
            end else begin
               cmd      = CMD_WR_A_RESP;
               state_in = ST_IDLE;
            end
         end
         ST_WR_B: begin
            cmd      = CMD_WR_B_RESP;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
endmodule

// ===== design/token_bucket_rate_shaper.sv =====
// Top level of the token bucket rate shaper: controller and datapath.
// Init and check skip the arithmetic; a consume refills each of its buckets (both for a pair)
// with the bit-serial multiply/divide unit, which sets the bulk of its duration.
// One transaction is in work at a time; the next one is accepted in the cycle the result shows.
// Synchronous reset empties every bucket and loads clock_hz with 1000000000.
// The result is presented for one cycle on rsp_strobe; the receiver cannot stall.
module token_bucket_rate_shaper (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [tbrs_pkg::OP_W-1:0]      req_opcode,
   input  logic [tbrs_pkg::BKT_W-1:0]     req_first_bucket,
   input  logic [tbrs_pkg::BKT_W-1:0]     req_second_bucket,
   input  logic [tbrs_pkg::TIME_W-1:0]    req_timestamp,
   input  logic [tbrs_pkg::LEN_W-1:0]     req_packet_length,
   input  logic [tbrs_pkg::RATE_W-1:0]    req_rate_kbps,
   output logic                           rsp_strobe,
   output logic                           rsp_granted,
   output logic [tbrs_pkg::TOK_W-1:0]     rsp_tokens_left,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tbrs_pkg::PADDR_W-1:0]   paddr,
   input  logic [tbrs_pkg::PDATA_W-1:0]   pwdata,
   output logic [tbrs_pkg::PDATA_W-1:0]   prdata,
   output logic                           pready
);
   import tbrs_pkg::*;

   cmd_type    cmd;
   status_type status;

   tbrs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   tbrs_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_opcode),
      .req_first_bucket  (req_first_bucket),
      .req_second_bucket (req_second_bucket),
      .req_timestamp     (req_timestamp),
      .req_packet_length (req_packet_length),
      .req_rate_kbps     (req_rate_kbps),
      .rsp_strobe        (rsp_strobe),
      .rsp_granted       (rsp_granted),
      .rsp_tokens_left   (rsp_tokens_left),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );
endmodule

// ===== design/tbrs_checker.sv =====
// Port-level checker for the token bucket rate shaper and its bind.
module tbrs_port_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("block did not go busy after accepting a transaction");

   a_strobe_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $fell(busy))
      else $error("result shown without finishing a transaction");

   a_busy_ends_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("transaction finished without a result");

   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");
endmodule

bind token_bucket_rate_shaper tbrs_port_checker u_tbrs_checker (.*);

// ===== bench/tbrs_checker.sv =====
// Bucket predictor and result checker of the token bucket rate shaper bench.
`timescale 1ns / 100ps
module tbrs_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [tbrs_pkg::OP_W-1:0]    req_opcode,
   input  logic [tbrs_pkg::BKT_W-1:0]   req_first_bucket,
   input  logic [tbrs_pkg::BKT_W-1:0]   req_second_bucket,
   input  logic [tbrs_pkg::TIME_W-1:0]  req_timestamp,
   input  logic [tbrs_pkg::LEN_W-1:0]   req_packet_length,
   input  logic [tbrs_pkg::RATE_W-1:0]  req_rate_kbps,
   input  logic                         rsp_strobe,
   input  logic                         rsp_granted,
   input  logic [tbrs_pkg::TOK_W-1:0]   rsp_tokens_left,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tbrs_pkg::PADDR_W-1:0] paddr,
   input  logic [tbrs_pkg::PDATA_W-1:0] pwdata,
   input  logic                         pready,
   output int                           fail_count,
   output int                           pending
);
   import tbrs_pkg::*;

   localparam logic [PADDR_W-1:0] CLOCK_HZ_ADDR = '0;

   typedef struct {
      logic             granted;
      logic [TOK_W-1:0] tokens;
   } shaper_result_type;

   shaper_result_type expected_results[$];
   logic [HZ_W-1:0]   tick_hz;
   logic [RATE_W-1:0] rate_tab[NUM_BUCKETS];
   logic [TOK_W-1:0]  depth_tab[NUM_BUCKETS];
   logic [TOK_W-1:0]  token_tab[NUM_BUCKETS];
   logic [TIME_W-1:0] stamp_tab[NUM_BUCKETS];

   function automatic logic [TOK_W-1:0] depth_of(logic [RATE_W-1:0] rate);
      logic [47:0] d;
      if (rate == 0) return '0;
      d = ({8'd0, rate} * 48'd100 + 48'd7) / 48'd8;
      return (d < 48'(MIN_DEPTH)) ? MIN_DEPTH : d[TOK_W-1:0];
   endfunction

   function automatic void refill_bucket(int b, logic [TIME_W-1:0] now);
      logic [127:0] hz, brate, gained, spent;
      logic [127:0] room;
      if (rate_tab[b] == 0 || depth_tab[b] == 0) begin
         token_tab[b] = '0;
         stamp_tab[b] = now;
         return;
      end
      if (token_tab[b] >= depth_tab[b]) begin
         token_tab[b] = depth_tab[b];
         stamp_tab[b] = now;
         return;
      end
      hz = (tick_hz == 0) ? 128'd1 : 128'(tick_hz);
      brate = 128'(rate_tab[b]) * 128'd125;
      gained = (128'(now - stamp_tab[b]) * brate) / hz;
      if (gained == 0) return;
      room = 128'(depth_tab[b] - token_tab[b]);
      if (gained >= room) begin
         token_tab[b] = depth_tab[b];
         stamp_tab[b] = now;
         return;
      end
      token_tab[b] = token_tab[b] + gained[TOK_W-1:0];
      spent = (gained * hz) / brate;
      if (spent[63:0] == 0) spent = 128'd1;
      stamp_tab[b] = stamp_tab[b] + spent[63:0];
   endfunction

   function automatic shaper_result_type predict_result();
      shaper_result_type r;
      opcode_type op;
      int a, b;
      op = opcode_type'(req_opcode);
      a = req_first_bucket;
      b = req_second_bucket;
      r.granted = 1'b0;
      if (op == OP_INIT) begin
         rate_tab[a] = req_rate_kbps;
         depth_tab[a] = depth_of(req_rate_kbps);
         token_tab[a] = depth_tab[a];
         stamp_tab[a] = req_timestamp;
         r.granted = 1'b1;
      end else if (op == OP_CHECK) begin
         r.granted = depth_tab[a] > 0 && TOK_W'(req_packet_length) <= depth_tab[a];
      end else if (op == OP_CONSUME || a == b) begin
         refill_bucket(a, req_timestamp);
         if (token_tab[a] >= TOK_W'(req_packet_length)) begin
            token_tab[a] = token_tab[a] - req_packet_length;
            r.granted = 1'b1;
         end
      end else begin
         refill_bucket(a, req_timestamp);
         refill_bucket(b, req_timestamp);
         if (token_tab[a] >= TOK_W'(req_packet_length) &&
             token_tab[b] >= TOK_W'(req_packet_length)) begin
            token_tab[a] = token_tab[a] - req_packet_length;
            token_tab[b] = token_tab[b] - req_packet_length;
            r.granted = 1'b1;
         end
      end
      r.tokens = token_tab[a];
      return r;
   endfunction

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      shaper_result_type want;
      if (reset) begin
         tick_hz = HZ_RESET;
         expected_results.delete();
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            rate_tab[i] = '0;
            depth_tab[i] = '0;
            token_tab[i] = '0;
            stamp_tab[i] = '0;
         end
      end else begin
         if (psel && penable && pwrite && pready && paddr == CLOCK_HZ_ADDR)
            tick_hz = pwdata[HZ_W-1:0];
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result granted=%0b tokens=%0d",
                           $realtime, rsp_granted, rsp_tokens_left);
            end else begin
               want = expected_results.pop_front();
               if (want.granted !== rsp_granted || want.tokens !== rsp_tokens_left) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: mismatch granted exp %0b got %0b, tokens exp %0d got %0d",
                              $realtime, want.granted, rsp_granted, want.tokens,
                              rsp_tokens_left);
               end
            end
         end
         if (start && !busy)
            expected_results.push_back(predict_result());
      end
      pending = expected_results.size();
   end

endmodule

// ===== bench/tb.sv =====
// Top of the token bucket rate shaper bench: stimulus, register writes and verdict.
`timescale 1ns / 100ps
module tb;
   import tbrs_pkg::*;

   localparam logic [PADDR_W-1:0] CLOCK_HZ_ADDR = '0;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [OP_W-1:0]    req_opcode;
   logic [BKT_W-1:0]   req_first_bucket;
   logic [BKT_W-1:0]   req_second_bucket;
   logic [TIME_W-1:0]  req_timestamp;
   logic [LEN_W-1:0]   req_packet_length;
   logic [RATE_W-1:0]  req_rate_kbps;
   logic               rsp_strobe;
   logic               rsp_granted;
   logic [TOK_W-1:0]   rsp_tokens_left;
   logic               psel, penable, pwrite, pready;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata, prdata;
   int                 fail_count, pending;
   int                 burst_left;
   logic [TIME_W-1:0]  now_ticks;

   token_bucket_rate_shaper DUT (.*);

   tbrs_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   task automatic send_request(opcode_type op, int a, int b, logic [TIME_W-1:0] ts,
                               logic [LEN_W-1:0] len, logic [RATE_W-1:0] rate);
      if (burst_left == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 25)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_opcode = op;
      req_first_bucket = BKT_W'(a);
      req_second_bucket = BKT_W'(b);
      req_timestamp = ts;
      req_packet_length = len;
      req_rate_kbps = rate;
      start = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      burst_left--;
      if (burst_left == 0) start = 1'b0;
   endtask

   task automatic write_clock_hz(logic [HZ_W-1:0] hz);
      start = 1'b0;
      burst_left = 0;
      while (pending != 0 || busy) @(negedge clock);
      repeat (10) @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      paddr = CLOCK_HZ_ADDR;
      pwdata = PDATA_W'(hz);
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   function automatic logic [RATE_W-1:0] pick_rate();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return RATE_W'($urandom_range(1, 100));
         2: return RATE_W'($urandom_range(100, 100000));
         3: return RATE_W'($urandom);
         4: return {8'($urandom), 32'($urandom)};
         default: return '1;
      endcase
   endfunction

   function automatic logic [LEN_W-1:0] pick_length();
      case ($urandom_range(0, 5))
         0: return '1;
         1: return LEN_W'($urandom);
         default: return LEN_W'($urandom_range(0, 3000));
      endcase
   endfunction

   task automatic random_request();
      int a, b, pick;
      logic [TIME_W-1:0] ts;
      a = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
      b = ($urandom_range(0, 3) == 0) ? a : $urandom_range(0, 7);
      if ($urandom_range(0, 9) == 0) b = $urandom_range(0, 255);
      case ($urandom_range(0, 9))
         0: ts = {32'($urandom), 32'($urandom)};
         1: ts = now_ticks + {32'($urandom), 32'($urandom)};
         2: ts = now_ticks + TIME_W'($urandom);
         3: ts = now_ticks;
         default: ts = now_ticks + TIME_W'($urandom_range(0, 200000));
      endcase
      now_ticks = ts;
      pick = $urandom_range(0, 9);
      if (pick < 2)
         send_request(OP_INIT, a, b, ts, pick_length(), pick_rate());
      else if (pick == 2)
         send_request(OP_CHECK, a, b, ts, pick_length(), pick_rate());
      else if (pick < 7)
         send_request(OP_CONSUME, a, b, ts, pick_length(), pick_rate());
      else
         send_request(OP_PAIR, a, b, ts, pick_length(), pick_rate());
   endtask

   initial begin
      #40_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [HZ_W-1:0] hz_list[5];
      reset = 1'b1;
      start = 1'b0;
      req_opcode = '0;
      req_first_bucket = '0;
      req_second_bucket = '0;
      req_timestamp = '0;
      req_packet_length = '0;
      req_rate_kbps = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      burst_left = 0;
      now_ticks = 64'd1000;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      send_request(OP_CHECK, 9, 9, 0, 0, 0);
      send_request(OP_INIT, 0, 0, 100, 0, 0);
      send_request(OP_INIT, 1, 1, 100, 0, 1);
      send_request(OP_INIT, 2, 2, 100, 0, '1);
      send_request(OP_INIT, 3, 3, 100, 0, 1000);
      send_request(OP_CHECK, 1, 0, 100, 2048, 0);
      send_request(OP_CHECK, 1, 0, 100, 2049, 0);
      send_request(OP_CHECK, 2, 0, 100, '1, 0);
      send_request(OP_CHECK, 0, 0, 100, 0, 0);
      send_request(OP_CONSUME, 0, 0, 200, 0, 0);
      send_request(OP_CONSUME, 1, 0, 100, 2000, 0);
      send_request(OP_CONSUME, 1, 0, 101, 100, 0);
      send_request(OP_CONSUME, 1, 0, 3_000_000, 10, 0);
      send_request(OP_CONSUME, 1, 0, 900_000_000, 1, 0);
      send_request(OP_CONSUME, 3, 0, 1_000_000, '1, 0);
      send_request(OP_CONSUME, 3, 0, 2_000_000, 60000, 0);
      send_request(OP_PAIR, 3, 3, 2_100_000, 10, 0);
      send_request(OP_PAIR, 1, 3, 2_200_000, 5, 0);
      send_request(OP_PAIR, 1, 0, 2_300_000, 5, 0);
      send_request(OP_PAIR, 2, 255, '1, 7, 0);
      send_request(OP_CONSUME, 2, 0, 64'd50, 65535, 0);
      send_request(OP_INIT, 255, 0, '1, '1, 40'd12345);
      send_request(OP_CONSUME, 255, 0, 64'd77, 3, 0);

      hz_list[0] = HZ_RESET;
      hz_list[1] = 33'd1;
      hz_list[2] = '1;
      hz_list[3] = '0;
      hz_list[4] = HZ_W'($urandom_range(1000, 200_000_000));
      for (int phase = 0; phase < 5; phase++) begin
         write_clock_hz(hz_list[phase]);
         for (int i = 0; i < 186; i++) random_request();
      end

      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (700) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
